### src/pdpf_pkg.sv
// Package for the protease digest peptide finder.
// Holds sizes, codes, the mask test and the accumulator control struct.
// No dependencies.
package pdpf_pkg;

   localparam int PROTEIN_LEN = 4096;
   localparam int PEPTIDE_LEN = 800;
   localparam int ADDR_W      = $clog2(PROTEIN_LEN);
   localparam int LEN_W       = ADDR_W + 1;
   localparam int POS_W       = ADDR_W + 2;
   localparam int ACC_W       = 32 + ADDR_W + 2;

   localparam logic signed [POS_W-1:0] POS_ONE = POS_W'(1);
   localparam logic signed [POS_W-1:0] POS_TWO = POS_W'(2);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PROTEIN_LEN);

   localparam logic [31:0] PROTON_Q16 = 32'd66013;
   localparam logic [6:0]  CODE_STAR  = 7'd42;
   localparam logic [6:0]  CODE_O     = 7'd111;
   localparam logic [6:0]  CODE_H     = 7'd104;
   localparam logic [6:0]  CODE_A     = 7'd65;
   localparam logic [6:0]  CODE_Z     = 7'd90;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_NEW    = 2'd2;
   localparam logic [1:0] OP_FETCH  = 2'd3;

   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_PEPTIDE = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;
   localparam logic [1:0] KIND_FULL    = 2'd3;

   localparam logic [2:0] CSR_MIN_MASS  = 3'd0;
   localparam logic [2:0] CSR_MAX_MASS  = 3'd1;
   localparam logic [2:0] CSR_MISSED    = 3'd2;
   localparam logic [2:0] CSR_CLEAVE    = 3'd3;
   localparam logic [2:0] CSR_BLOCK     = 3'd4;

   typedef struct packed {
      logic        clear;
      logic        add;
      logic [31:0] operand;
   } acc_ctl_type;

   function automatic logic in_mask(input logic [25:0] mask, input logic [6:0] code);
      logic [6:0] off;
      off = code - CODE_A;
      return (code >= CODE_A) && (code <= CODE_Z) && mask[off[4:0]];
   endfunction

endpackage

### src/pdpf_req_if.sv
// Request channel: opcode, residue code and mass word.
// No dependencies.
interface pdpf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [6:0]  residue;
   logic [31:0] residue_mass;
   modport source (output valid, opcode, residue, residue_mass, input ready);
   modport sink   (input valid, opcode, residue, residue_mass, output ready);
endinterface

### src/pdpf_rsp_if.sv
// Response channel: one result word per request.
// No dependencies.
interface pdpf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [11:0] first_index;
   logic [11:0] last_index;
   logic [31:0] peptide_mass;
   logic [6:0]  residue_before;
   logic [6:0]  residue_after;
   modport source (output valid, kind, first_index, last_index, peptide_mass,
                   residue_before, residue_after, input ready);
   modport sink   (input valid, kind, first_index, last_index, peptide_mass,
                   residue_before, residue_after, output ready);
endinterface

### src/pdpf_csr_if.sv
// Register write channel: index and data.
// No dependencies.
interface pdpf_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/protease_digest_peptide_finder.sv
// Tryptic-style digest engine. Load, append and new-protein words answer with a
// registered response in the cycle after they are taken. A fetch walks the stored
// sequence with one shared accumulator and a single read port on each memory:
// each residue scanned for a site passes the top, cleavage and next states, each
// residue summed into a candidate window passes the read, table and add states
// (the window is resummed at every site), and each site then adds the terminal
// masses and reads the neighbours. The block takes no new word while a fetch runs.
module protease_digest_peptide_finder import pdpf_pkg::*; (
   input logic      clock,
   input logic      reset,
   pdpf_req_if.sink   req,
   pdpf_rsp_if.source rsp,
   pdpf_csr_if.sink   csr
);
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_TOP  = 4'd1;
   localparam logic [3:0] ST_C    = 4'd2;
   localparam logic [3:0] ST_N    = 4'd3;
   localparam logic [3:0] ST_SRD  = 4'd4;
   localparam logic [3:0] ST_STB  = 4'd5;
   localparam logic [3:0] ST_SADD = 4'd6;
   localparam logic [3:0] ST_TH1  = 4'd7;
   localparam logic [3:0] ST_TH2  = 4'd8;
   localparam logic [3:0] ST_TH3  = 4'd9;
   localparam logic [3:0] ST_TP   = 4'd10;
   localparam logic [3:0] ST_B0   = 4'd11;
   localparam logic [3:0] ST_B1   = 4'd12;
   localparam logic [3:0] ST_B2   = 4'd13;
   localparam logic [3:0] ST_OUT  = 4'd14;

   logic [3:0] state_ff, state_in;

   logic [31:0] min_mass_ff, max_mass_ff;
   logic [3:0]  limit_ff;
   logic [25:0] cleave_ff, block_ff;

   logic [LEN_W-1:0] len_ff, len_in;
   logic signed [POS_W-1:0] ws_ff, ws_in, we_ff, we_in, ns_ff, ns_in;
   logic signed [POS_W-1:0] e_ff, e_in, i_ff, i_in;
   logic [4:0] mc_ff, mc_in;
   logic [6:0] c_ff, c_in, before_ff, before_in;

   logic        pend_peptide_ff, pend_peptide_in;
   logic [11:0] pend_first_ff, pend_first_in, pend_last_ff, pend_last_in;
   logic [31:0] pend_mass_ff, pend_mass_in;
   logic [6:0]  pend_before_ff, pend_before_in, pend_after_ff, pend_after_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [11:0] rsp_first_ff, rsp_first_in, rsp_last_ff, rsp_last_in;
   logic [31:0] rsp_mass_ff, rsp_mass_in;
   logic [6:0]  rsp_before_ff, rsp_before_in, rsp_after_ff, rsp_after_in;

   logic req_ready, req_fire, out_free;
   logic signed [POS_W-1:0] len_s, rd_pos;
   logic rd_ok, rd_ok_ff;
   logic [6:0] seq_q, res;
   logic seq_wr;
   logic [6:0] tbl_rd_addr;
   logic [31:0] tbl_q, mass;
   logic tbl_wr;
   acc_ctl_type acc_ctl;

   logic site;
   logic signed [POS_W:0] pep_len;
   logic emit, cont;
   logic [4:0] mc_inc;
   logic signed [POS_W-1:0] ns_adv;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req.valid && req_ready;
   assign req.ready = req_ready;
   assign csr.ready = 1'b1;
   assign len_s     = signed'({1'b0, len_ff});

   assign seq_wr = req_fire && (req.opcode == OP_APPEND) && (len_ff < LEN_MAX);
   assign tbl_wr = req_fire && (req.opcode == OP_LOAD);

   pdpf_seq_store u_seq (
      .clock   (clock),
      .wr_en   (seq_wr),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_data (req.residue),
      .rd_addr (rd_pos[ADDR_W-1:0]),
      .rd_data (seq_q)
   );

   pdpf_mass_table u_tbl (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (req.residue),
      .wr_data (req.residue_mass),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_q)
   );

   pdpf_accum u_acc (
      .clock (clock),
      .ctl   (acc_ctl),
      .mass  (mass)
   );

   // positions outside the sequence read as code zero
   assign res = rd_ok_ff ? seq_q : 7'd0;

   always_comb begin
      unique case (state_ff)
         ST_C:    rd_pos = we_ff + POS_ONE;
         ST_SRD:  rd_pos = i_ff;
         ST_B0:   rd_pos = ws_ff - POS_ONE;
         ST_B1:   rd_pos = e_ff + POS_ONE;
         default: rd_pos = we_ff;
      endcase
      rd_ok = (rd_pos >= 0) && (rd_pos < len_s);
   end

   always_comb begin
      unique case (state_ff)
         ST_SRD:         tbl_rd_addr = CODE_O;
         ST_STB:         tbl_rd_addr = res;
         ST_TH1, ST_TH2: tbl_rd_addr = CODE_H;
         default:        tbl_rd_addr = 7'd0;
      endcase
   end

   always_comb begin
      site    = (in_mask(cleave_ff, c_ff) && !in_mask(block_ff, res))
                || (c_ff == CODE_STAR) || (we_ff == len_s - POS_ONE);
      pep_len = ({e_ff[POS_W-1], e_ff} - {ws_ff[POS_W-1], ws_ff}) + (POS_W+1)'(2);
      emit    = (e_ff >= ws_ff) && (mass >= min_mass_ff) && (mass <= max_mass_ff)
                && (pep_len < (POS_W+1)'(PEPTIDE_LEN));
      mc_inc  = mc_ff + 5'd1;
      ns_adv  = (mc_inc == 5'd1) ? e_ff + POS_ONE : ns_ff;
      cont    = (mc_inc <= {1'b0, limit_ff}) && (mass < max_mass_ff)
                && (e_ff < len_s - POS_ONE);
   end

   always_comb begin
      state_in = state_ff;
      len_in = len_ff;
      ws_in = ws_ff;  we_in = we_ff;  ns_in = ns_ff;
      e_in = e_ff;    i_in = i_ff;    mc_in = mc_ff;
      c_in = c_ff;    before_in = before_ff;
      pend_peptide_in = pend_peptide_ff;
      pend_first_in = pend_first_ff;   pend_last_in = pend_last_ff;
      pend_mass_in = pend_mass_ff;
      pend_before_in = pend_before_ff; pend_after_in = pend_after_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_kind_in = rsp_kind_ff;
      rsp_first_in = rsp_first_ff;   rsp_last_in = rsp_last_ff;
      rsp_mass_in = rsp_mass_ff;
      rsp_before_in = rsp_before_ff; rsp_after_in = rsp_after_ff;
      acc_ctl = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_kind_in = KIND_ACK;
               rsp_first_in = '0; rsp_last_in = '0; rsp_mass_in = '0;
               rsp_before_in = '0; rsp_after_in = '0;
               unique case (req.opcode)
                  OP_LOAD: rsp_valid_in = 1'b1;
                  OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (len_ff < LEN_MAX) begin
                        len_in = len_ff + LEN_W'(1);
                     end else begin
                        rsp_kind_in = KIND_FULL;
                     end
                  end
                  OP_NEW: begin
                     rsp_valid_in = 1'b1;
                     len_in = '0; ws_in = '0; we_in = '0; ns_in = '0; mc_in = '0;
                  end
                  default: state_in = ST_TOP;
               endcase
            end
         end
         ST_TOP: begin
            if (ws_ff >= len_s) begin
               pend_peptide_in = 1'b0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_C;
            end
         end
         ST_C: begin
            c_in = res;
            state_in = ST_N;
         end
         ST_N: begin
            if (!site) begin
               we_in = we_ff + POS_ONE;
               state_in = ST_TOP;
            end else begin
               e_in = (c_ff == CODE_STAR) ? we_ff - POS_ONE : we_ff;
               i_in = ws_ff;
               acc_ctl.clear = 1'b1;
               state_in = ST_SRD;
            end
         end
         ST_SRD: state_in = (i_ff > e_ff) ? ST_TH1 : ST_STB;
         ST_STB: state_in = ST_SADD;
         ST_SADD: begin
            acc_ctl.add = 1'b1;
            acc_ctl.operand = tbl_q;
            i_in = i_ff + POS_ONE;
            state_in = ST_SRD;
         end
         ST_TH1, ST_TH2, ST_TH3: begin
            acc_ctl.add = 1'b1;
            acc_ctl.operand = tbl_q;
            state_in = state_ff + 4'd1;
         end
         ST_TP: begin
            acc_ctl.add = 1'b1;
            acc_ctl.operand = PROTON_Q16;
            state_in = ST_B0;
         end
         ST_B0: state_in = ST_B1;
         ST_B1: begin
            before_in = res;
            state_in = ST_B2;
         end
         ST_B2: begin
            pend_peptide_in = 1'b1;
            pend_first_in = ws_ff[11:0];
            pend_last_in = e_ff[11:0];
            pend_mass_in = mass;
            pend_before_in = before_ff;
            pend_after_in = res;
            state_in = emit ? ST_OUT : ST_TOP;
            if (res == CODE_STAR) begin
               // forced break: a window that began at the pending restart moves past it
               if (ws_ff == ns_ff) begin
                  mc_in = '0;
                  ns_in = e_ff + POS_TWO;
                  ws_in = e_ff + POS_TWO;
                  we_in = e_ff + POS_TWO;
               end else begin
                  mc_in = '0; ws_in = ns_ff; we_in = ns_ff;
               end
            end else begin
               ns_in = ns_adv;
               if (cont) begin
                  mc_in = mc_inc;
                  we_in = e_ff + POS_ONE;
               end else begin
                  mc_in = '0; ws_in = ns_adv; we_in = ns_adv;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pend_peptide_ff) begin
                  rsp_kind_in = KIND_PEPTIDE;
                  rsp_first_in = pend_first_ff;  rsp_last_in = pend_last_ff;
                  rsp_mass_in = pend_mass_ff;
                  rsp_before_in = pend_before_ff; rsp_after_in = pend_after_ff;
               end else begin
                  rsp_kind_in = KIND_DONE;
                  rsp_first_in = '0; rsp_last_in = '0; rsp_mass_in = '0;
                  rsp_before_in = '0; rsp_after_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff <= '0;
         ws_ff <= '0; we_ff <= '0; ns_ff <= '0; mc_ff <= '0;
         rsp_valid_ff <= 1'b0;
         min_mass_ff <= 32'd52428800;
         max_mass_ff <= 32'd196608000;
         limit_ff <= 4'd1;
         cleave_ff <= 26'd132096;
         block_ff <= 26'd32768;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         ws_ff <= ws_in; we_ff <= we_in; ns_ff <= ns_in; mc_ff <= mc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid) begin
            unique case (csr.index)
               CSR_MIN_MASS: min_mass_ff <= csr.data;
               CSR_MAX_MASS: max_mass_ff <= csr.data;
               CSR_MISSED:   limit_ff <= csr.data[3:0];
               CSR_CLEAVE:   cleave_ff <= csr.data[25:0];
               CSR_BLOCK:    block_ff <= csr.data[25:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ok_ff <= rd_ok;
      e_ff <= e_in; i_ff <= i_in; c_ff <= c_in; before_ff <= before_in;
      pend_peptide_ff <= pend_peptide_in;
      pend_first_ff <= pend_first_in; pend_last_ff <= pend_last_in;
      pend_mass_ff <= pend_mass_in;
      pend_before_ff <= pend_before_in; pend_after_ff <= pend_after_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_first_ff <= rsp_first_in; rsp_last_ff <= rsp_last_in;
      rsp_mass_ff <= rsp_mass_in;
      rsp_before_ff <= rsp_before_in; rsp_after_ff <= rsp_after_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.kind           = rsp_kind_ff;
   assign rsp.first_index    = rsp_first_ff;
   assign rsp.last_index     = rsp_last_ff;
   assign rsp.peptide_mass   = rsp_mass_ff;
   assign rsp.residue_before = rsp_before_ff;
   assign rsp.residue_after  = rsp_after_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready)
      else $error("request taken during fetch");
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_MAX)
      else $error("sequence length past store depth");
   // the limit may be lowered between fetches, so only the absolute ceiling holds
   a_missed_bound: assert property (@(posedge clock) disable iff (reset)
      mc_ff <= 5'd15)
      else $error("missed count past limit");
   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("fetch word not delivered");
endmodule

### src/pdpf_seq_store.sv
// Protein sequence memory, one residue code per entry, registered read.
// Depends on pdpf_pkg.
module pdpf_seq_store import pdpf_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [6:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [6:0]        rd_data
);
   logic [6:0] mem [PROTEIN_LEN];
   logic [6:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### src/pdpf_mass_table.sv
// Residue mass table, 128 words of Q16.16, registered read.
// No dependencies.
module pdpf_mass_table (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [6:0]  wr_addr,
   input  logic [31:0] wr_data,
   input  logic [6:0]  rd_addr,
   output logic [31:0] rd_data
);
   logic [31:0] mem [128];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### src/pdpf_accum.sv
// Shared mass accumulator: one add per cycle, saturated 32-bit view.
// Depends on pdpf_pkg.
module pdpf_accum import pdpf_pkg::*; (
   input  logic        clock,
   input  acc_ctl_type ctl,
   output logic [31:0] mass
);
   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.add) begin
         acc_in = acc_ff + ACC_W'(ctl.operand);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign mass = (|acc_ff[ACC_W-1:32]) ? 32'hFFFF_FFFF : acc_ff[31:0];
endmodule
